// ===== src/pfld_pkg.sv =====
// Package for the page framebuffer line drawer.
// Field widths, command and register codes, controller and datapath types.
// No dependencies.
package pfld_pkg;

   localparam int MAX_COLUMNS_DEF = 128;
   localparam int MAX_PAGES_DEF   = 8;

   localparam int TYPE_W     = 3;
   localparam int COORD_W    = 9;
   localparam int PAGE_W     = 3;
   localparam int COL_W      = 7;
   localparam int DATA_W     = 8;
   localparam int WIDTH_W    = 8;
   localparam int HEIGHT_W   = 7;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 8;
   localparam int POS_Y_W    = 12;
   localparam int ERR_W      = 12;
   localparam int ADDR_WIDE_W = 24;

   localparam logic [WIDTH_W-1:0]  WIDTH_RST  = 8'd128;
   localparam logic [HEIGHT_W-1:0] HEIGHT_RST = 7'd64;

   localparam logic [CSR_IDX_W-1:0] CSR_CANVAS_WIDTH  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_CANVAS_HEIGHT = 1'b1;

   localparam logic [TYPE_W-1:0] REQ_SET_PIXEL  = 3'd0;
   localparam logic [TYPE_W-1:0] REQ_CLR_PIXEL  = 3'd1;
   localparam logic [TYPE_W-1:0] REQ_DRAW_LINE  = 3'd2;
   localparam logic [TYPE_W-1:0] REQ_CLR_CANVAS = 3'd3;
   localparam logic [TYPE_W-1:0] REQ_READ_BYTE  = 3'd4;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_DECODE,
      ST_PIX,
      ST_WR,
      ST_CLEAR,
      ST_READ_WAIT,
      ST_DONE
   } ctrl_state_type;

   typedef enum logic [3:0] {
      DP_NOP,
      DP_INIT,
      DP_LOAD,
      DP_SETUP,
      DP_PIX_RD,
      DP_PIX_WR,
      DP_ADV,
      DP_CLR,
      DP_RD,
      DP_CAP,
      DP_FINISH
   } dp_op_type;

   typedef enum logic [1:0] {
      MODE_SINGLE,
      MODE_VERT,
      MODE_DIAG
   } line_mode_type;

   typedef struct packed {
      dp_op_type op;
   } dp_cmd_type;

   typedef struct packed {
      logic [TYPE_W-1:0] req_code;
      logic              plot;
      logic              adv_last;
      logic              clr_none;
      logic              clr_last;
      logic              init_last;
      logic              rsp_busy;
   } dp_status_type;

endpackage

// ===== src/pfld_if.sv =====
// Request and response channel interfaces for the line drawer.
// Depends on pfld_pkg for field widths.
interface pfld_req_if import pfld_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [TYPE_W-1:0]   req_type;
   logic [COORD_W-1:0]  start_x;
   logic [COORD_W-1:0]  start_y;
   logic [COORD_W-1:0]  end_x;
   logic [COORD_W-1:0]  end_y;
   logic                dashed;
   logic [PAGE_W-1:0]   read_page;
   logic [COL_W-1:0]    read_column;

   modport source (
      output valid, req_type, start_x, start_y, end_x, end_y, dashed, read_page, read_column,
      input  ready
   );
   modport sink (
      input  valid, req_type, start_x, start_y, end_x, end_y, dashed, read_page, read_column,
      output ready
   );
endinterface

interface pfld_rsp_if import pfld_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [DATA_W-1:0]  read_data;
   logic               was_read;

   modport source (output valid, read_data, was_read, input ready);
   modport sink (input valid, read_data, was_read, output ready);
endinterface

// ===== src/pfld_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pfld_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/pfld_ctrl.sv =====
// Controller state machine of the line drawer: sequences the datapath.
// Depends on pfld_pkg.
module pfld_ctrl import pfld_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   output dp_cmd_type    cmd,
   input  dp_status_type st
);

   ctrl_state_type state_ff;
   ctrl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd.op    = DP_NOP;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_INIT: begin
            cmd.op = DP_INIT;
            if (st.init_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.op   = DP_LOAD;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            unique case (st.req_code) inside
               REQ_SET_PIXEL, REQ_CLR_PIXEL: begin
                  state_in = ST_PIX;
               end
               REQ_DRAW_LINE: begin
                  cmd.op   = DP_SETUP;
                  state_in = ST_PIX;
               end
               REQ_CLR_CANVAS: begin
                  state_in = ST_CLEAR;
               end
               REQ_READ_BYTE: begin
                  cmd.op   = DP_RD;
                  state_in = ST_READ_WAIT;
               end
               default: begin
                  state_in = ST_DONE;
               end
            endcase
         end
         ST_PIX: begin
            if (st.plot) begin
               cmd.op   = DP_PIX_RD;
               state_in = ST_WR;
            end else begin
               cmd.op = DP_ADV;
               if (st.adv_last) begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_WR: begin
            cmd.op   = DP_PIX_WR;
            state_in = st.adv_last ? ST_DONE : ST_PIX;
         end
         ST_CLEAR: begin
            if (st.clr_none) begin
               state_in = ST_DONE;
            end else begin
               cmd.op = DP_CLR;
               if (st.clr_last) begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_READ_WAIT: begin
            cmd.op   = DP_CAP;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!st.rsp_busy) begin
               cmd.op   = DP_FINISH;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ===== src/pfld_dp.sv =====
// Datapath of the line drawer: command registers, line stepper, clear sweep,
// store addressing, configuration registers and the result register. Depends on pfld_pkg.
module pfld_dp import pfld_pkg::*; #(
   parameter int MAX_COLUMNS = MAX_COLUMNS_DEF,
   parameter int MAX_PAGES   = MAX_PAGES_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  dp_cmd_type                             cmd,
   output dp_status_type                          st,
   input  logic                                   csr_wr_en,
   input  logic [CSR_IDX_W-1:0]                   csr_index,
   input  logic [CSR_DATA_W-1:0]                  csr_wr_data,
   input  logic [TYPE_W-1:0]                      req_type,
   input  logic [COORD_W-1:0]                     start_x,
   input  logic [COORD_W-1:0]                     start_y,
   input  logic [COORD_W-1:0]                     end_x,
   input  logic [COORD_W-1:0]                     end_y,
   input  logic                                   dashed,
   input  logic [PAGE_W-1:0]                      read_page,
   input  logic [COL_W-1:0]                       read_column,
   input  logic                                   rsp_ready,
   output logic                                   rsp_valid,
   output logic [DATA_W-1:0]                      rsp_read_data,
   output logic                                   rsp_was_read,
   output logic                                   mem_we,
   output logic                                   mem_re,
   output logic [$clog2(MAX_PAGES*MAX_COLUMNS)-1:0] mem_addr,
   output logic [DATA_W-1:0]                      mem_wdata,
   input  logic [DATA_W-1:0]                      mem_rdata
);

   localparam int DEPTH  = MAX_PAGES * MAX_COLUMNS;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int PW     = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
   localparam int CW     = $clog2(MAX_COLUMNS);
   localparam int ROWS   = 8 * MAX_PAGES;

   // request registers
   logic [TYPE_W-1:0]  type_ff, type_in;
   logic [COORD_W-1:0] sx_ff, sx_in, sy_ff, sy_in, ex_ff, ex_in, ey_ff, ey_in;
   logic               dashed_ff, dashed_in;
   logic [PAGE_W-1:0]  rpage_ff, rpage_in;
   logic [COL_W-1:0]   rcol_ff, rcol_in;
   logic               on_ff, on_in;

   // line stepper
   line_mode_type             mode_ff, mode_in;
   logic [COORD_W-1:0]        px_ff, px_in;
   logic signed [POS_Y_W-1:0] py_ff, py_in;
   logic [COORD_W-1:0]        hi_ff, hi_in;
   logic [COORD_W-1:0]        x1_ff, x1_in;
   logic [COORD_W-1:0]        dx_ff, dx_in;
   logic [COORD_W-1:0]        ady_ff, ady_in;
   logic                      step_neg_ff, step_neg_in;
   logic signed [ERR_W-1:0]   e_ff, e_in;
   logic                      phase_main_ff, phase_main_in;
   logic                      dash_ff, dash_in;
   logic                      plot_en_ff, plot_en_in;

   // sweeps, read byte, result, configuration
   logic [PW-1:0]       clr_page_ff, clr_page_in;
   logic [CW-1:0]       clr_col_ff, clr_col_in;
   logic [ADDR_W-1:0]   init_addr_ff, init_addr_in;
   logic [DATA_W-1:0]   rd_byte_ff, rd_byte_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0]   rsp_data_ff, rsp_data_in;
   logic                rsp_was_read_ff, rsp_was_read_in;
   logic [WIDTH_W-1:0]  width_ff, width_in;
   logic [HEIGHT_W-1:0] height_ff, height_in;

   // combinational helpers
   logic                      swap;
   logic [COORD_W-1:0]        lx0, ly0, lx1, ly1;
   logic signed [ERR_W-1:0]   e_cur, e_sub;
   logic signed [ERR_W:0]     twice_e, dx_ext;
   logic                      y_step;
   logic                      adv_last;
   logic                      px_ok, py_ok;
   logic [ADDR_WIDE_W-1:0]    pix_addr_wide, clr_addr_wide, rd_addr_wide;
   logic [4:0]                pages_lim;
   logic [8:0]                cols_lim;
   logic                      col_end, page_end;
   logic                      rd_ok;
   logic [DATA_W-1:0]         bit_mask, mod_byte;

   assign swap = sx_ff > ex_ff;
   assign lx0  = swap ? ex_ff : sx_ff;
   assign ly0  = swap ? ey_ff : sy_ff;
   assign lx1  = swap ? sx_ff : ex_ff;
   assign ly1  = swap ? sy_ff : ey_ff;

   assign e_cur   = phase_main_ff ? e_ff + ERR_W'(ady_ff) : e_ff;
   assign e_sub   = e_cur - ERR_W'(dx_ff);
   assign twice_e = {e_cur, 1'b0};
   assign dx_ext  = (ERR_W + 1)'(dx_ff);
   assign y_step  = twice_e > dx_ext;

   always_comb begin
      unique case (mode_ff)
         MODE_VERT: adv_last = (py_ff + POS_Y_W'(1)) == POS_Y_W'(hi_ff);
         MODE_DIAG: adv_last = !y_step && (px_ff == x1_ff);
         default:   adv_last = 1'b1;
      endcase
   end

   assign px_ok = ({1'b0, px_ff} < 10'(MAX_COLUMNS)) && (px_ff < {1'b0, width_ff});
   assign py_ok = !py_ff[POS_Y_W-1]
                  && (py_ff[POS_Y_W-2:0] < (POS_Y_W - 1)'(height_ff))
                  && (py_ff[POS_Y_W-2:0] < (POS_Y_W - 1)'(ROWS));

   assign pix_addr_wide = ADDR_WIDE_W'(py_ff[POS_Y_W-2:3]) * ADDR_WIDE_W'(MAX_COLUMNS)
                          + ADDR_WIDE_W'(px_ff);
   assign clr_addr_wide = ADDR_WIDE_W'(clr_page_ff) * ADDR_WIDE_W'(MAX_COLUMNS)
                          + ADDR_WIDE_W'(clr_col_ff);
   assign rd_addr_wide  = ADDR_WIDE_W'(rpage_ff) * ADDR_WIDE_W'(MAX_COLUMNS)
                          + ADDR_WIDE_W'(rcol_ff);

   assign pages_lim = (5'(height_ff[HEIGHT_W-1:3]) > 5'(MAX_PAGES)) ?
                      5'(MAX_PAGES) : 5'(height_ff[HEIGHT_W-1:3]);
   assign cols_lim  = (9'(width_ff) > 9'(MAX_COLUMNS)) ? 9'(MAX_COLUMNS) : 9'(width_ff);
   assign col_end   = 9'(clr_col_ff) == (cols_lim - 9'd1);
   assign page_end  = 5'(clr_page_ff) == (pages_lim - 5'd1);

   assign rd_ok = (5'(rpage_ff) < 5'(MAX_PAGES)) && (9'(rcol_ff) < 9'(MAX_COLUMNS));

   assign bit_mask = DATA_W'(1) << py_ff[2:0];
   assign mod_byte = on_ff ? (mem_rdata | bit_mask) : (mem_rdata & ~bit_mask);

   assign st.req_code  = type_ff;
   assign st.plot      = plot_en_ff && px_ok && py_ok;
   assign st.adv_last  = adv_last;
   assign st.clr_none  = (pages_lim == 5'd0) || (cols_lim == 9'd0);
   assign st.clr_last  = col_end && page_end;
   assign st.init_last = init_addr_ff == ADDR_W'(DEPTH - 1);
   assign st.rsp_busy  = rsp_valid_ff && !rsp_ready;

   always_comb begin
      type_in         = type_ff;
      sx_in           = sx_ff;
      sy_in           = sy_ff;
      ex_in           = ex_ff;
      ey_in           = ey_ff;
      dashed_in       = dashed_ff;
      rpage_in        = rpage_ff;
      rcol_in         = rcol_ff;
      on_in           = on_ff;
      mode_in         = mode_ff;
      px_in           = px_ff;
      py_in           = py_ff;
      hi_in           = hi_ff;
      x1_in           = x1_ff;
      dx_in           = dx_ff;
      ady_in          = ady_ff;
      step_neg_in     = step_neg_ff;
      e_in            = e_ff;
      phase_main_in   = phase_main_ff;
      dash_in         = dash_ff;
      plot_en_in      = plot_en_ff;
      clr_page_in     = clr_page_ff;
      clr_col_in      = clr_col_ff;
      init_addr_in    = init_addr_ff;
      rd_byte_in      = rd_byte_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      rsp_data_in     = rsp_data_ff;
      rsp_was_read_in = rsp_was_read_ff;
      width_in        = width_ff;
      height_in       = height_ff;
      mem_we          = 1'b0;
      mem_re          = 1'b0;
      mem_addr        = pix_addr_wide[ADDR_W-1:0];
      mem_wdata       = '0;

      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_CANVAS_WIDTH:  width_in  = csr_wr_data[WIDTH_W-1:0];
            CSR_CANVAS_HEIGHT: height_in = csr_wr_data[HEIGHT_W-1:0];
            default: ;
         endcase
      end

      unique case (cmd.op) inside
         DP_INIT: begin
            mem_we       = 1'b1;
            mem_addr     = init_addr_ff;
            init_addr_in = init_addr_ff + ADDR_W'(1);
         end
         DP_LOAD: begin
            type_in     = req_type;
            sx_in       = start_x;
            sy_in       = start_y;
            ex_in       = end_x;
            ey_in       = end_y;
            dashed_in   = dashed;
            rpage_in    = read_page;
            rcol_in     = read_column;
            on_in       = req_type != REQ_CLR_PIXEL;
            mode_in     = MODE_SINGLE;
            px_in       = start_x;
            py_in       = POS_Y_W'(start_y);
            plot_en_in  = 1'b1;
            dash_in     = 1'b0;
            clr_page_in = '0;
            clr_col_in  = '0;
         end
         DP_SETUP: begin
            if ((sx_ff == ex_ff) && (sy_ff == ey_ff)) begin
               mode_in = MODE_SINGLE;
               px_in   = sx_ff;
               py_in   = POS_Y_W'(sy_ff);
            end else if (sx_ff == ex_ff) begin
               mode_in = MODE_VERT;
               px_in   = lx0;
               py_in   = POS_Y_W'((ly0 < ly1) ? ly0 : ly1);
               hi_in   = (ly0 < ly1) ? ly1 : ly0;
            end else begin
               mode_in       = MODE_DIAG;
               px_in         = lx0;
               py_in         = POS_Y_W'(ly0);
               x1_in         = lx1;
               dx_in         = lx1 - lx0;
               step_neg_in   = ly1 < ly0;
               ady_in        = (ly1 < ly0) ? (ly0 - ly1) : (ly1 - ly0);
               e_in          = '0;
               phase_main_in = 1'b1;
            end
         end
         DP_PIX_RD: begin
            mem_re = 1'b1;
         end
         DP_PIX_WR, DP_ADV: begin
            if (cmd.op == DP_PIX_WR) begin
               mem_we    = 1'b1;
               mem_wdata = mod_byte;
            end
            unique case (mode_ff)
               MODE_VERT: begin
                  py_in      = py_ff + POS_Y_W'(1);
                  dash_in    = !dash_ff;
                  plot_en_in = !dashed_ff || dash_ff;
               end
               MODE_DIAG: begin
                  if (y_step) begin
                     py_in         = step_neg_ff ? py_ff - POS_Y_W'(1) : py_ff + POS_Y_W'(1);
                     e_in          = e_sub;
                     phase_main_in = 1'b0;
                     plot_en_in    = 1'b1;
                  end else begin
                     e_in          = e_cur;
                     px_in         = px_ff + COORD_W'(1);
                     dash_in       = !dash_ff;
                     plot_en_in    = !dashed_ff || dash_ff;
                     phase_main_in = 1'b1;
                  end
               end
               default: ;
            endcase
         end
         DP_CLR: begin
            mem_we   = 1'b1;
            mem_addr = clr_addr_wide[ADDR_W-1:0];
            if (col_end) begin
               clr_col_in  = '0;
               clr_page_in = clr_page_ff + PW'(1);
            end else begin
               clr_col_in = clr_col_ff + CW'(1);
            end
         end
         DP_RD: begin
            mem_re   = 1'b1;
            mem_addr = rd_addr_wide[ADDR_W-1:0];
         end
         DP_CAP: begin
            rd_byte_in = rd_ok ? mem_rdata : '0;
         end
         DP_FINISH: begin
            rsp_valid_in    = 1'b1;
            rsp_was_read_in = type_ff == REQ_READ_BYTE;
            rsp_data_in     = (type_ff == REQ_READ_BYTE) ? rd_byte_ff : '0;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_SINGLE;
         init_addr_ff <= '0;
         rsp_valid_ff <= 1'b0;
         width_ff     <= WIDTH_RST;
         height_ff    <= HEIGHT_RST;
      end else begin
         mode_ff      <= mode_in;
         init_addr_ff <= init_addr_in;
         rsp_valid_ff <= rsp_valid_in;
         width_ff     <= width_in;
         height_ff    <= height_in;
      end
   end

   always_ff @(posedge clock) begin
      type_ff         <= type_in;
      sx_ff           <= sx_in;
      sy_ff           <= sy_in;
      ex_ff           <= ex_in;
      ey_ff           <= ey_in;
      dashed_ff       <= dashed_in;
      rpage_ff        <= rpage_in;
      rcol_ff         <= rcol_in;
      on_ff           <= on_in;
      px_ff           <= px_in;
      py_ff           <= py_in;
      hi_ff           <= hi_in;
      x1_ff           <= x1_in;
      dx_ff           <= dx_in;
      ady_ff          <= ady_in;
      step_neg_ff     <= step_neg_in;
      e_ff            <= e_in;
      phase_main_ff   <= phase_main_in;
      dash_ff         <= dash_in;
      plot_en_ff      <= plot_en_in;
      clr_page_ff     <= clr_page_in;
      clr_col_ff      <= clr_col_in;
      rd_byte_ff      <= rd_byte_in;
      rsp_data_ff     <= rsp_data_in;
      rsp_was_read_ff <= rsp_was_read_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_read_data = rsp_data_ff;
   assign rsp_was_read  = rsp_was_read_ff;

endmodule

// ===== src/page_framebuffer_line_drawer.sv =====
// Top level of the page framebuffer line drawer: controller, datapath and frame store.
// Depends on pfld_pkg, pfld_if, pfld_ram, pfld_ctrl and pfld_dp.
//
//  channel | direction | handshake        | payload
//  req     | in        | valid / ready    | req_type start_x start_y end_x end_y dashed
//          |           |                  | read_page read_column
//  rsp     | out       | valid / ready    | read_data was_read
//  csr     | in        | csr_wr_en        | csr_index csr_wr_data
//
// One command at a time. Set/clear pixel: a read-modify-write of the pixel's store byte,
// skipped if clipped. Read byte: a read of the store. Unknown code: no store access. Line:
// a setup step, then per pixel a read-modify-write if plotted, or only an advance if clipped
// or dashed out. Clear canvas: zero writes over pages x columns. After reset the store's
// MAX_PAGES*MAX_COLUMNS words (1024 by default) are zeroed, req.ready low throughout. A new beat
// is taken while the previous result waits on rsp; the next result then waits for rsp to drain.
module page_framebuffer_line_drawer import pfld_pkg::*; #(
   parameter int MAX_COLUMNS = MAX_COLUMNS_DEF,
   parameter int MAX_PAGES   = MAX_PAGES_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   pfld_req_if.sink              req,
   pfld_rsp_if.source            rsp,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wr_data
);

   localparam int DEPTH  = MAX_PAGES * MAX_COLUMNS;
   localparam int ADDR_W = $clog2(DEPTH);

   dp_cmd_type        cmd;
   dp_status_type     st;
   logic              ctrl_ready;
   logic              mem_we;
   logic              mem_re;
   logic [ADDR_W-1:0] mem_addr;
   logic [DATA_W-1:0] mem_wdata;
   logic [DATA_W-1:0] mem_rdata;

   pfld_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (ctrl_ready),
      .cmd       (cmd),
      .st        (st)
   );

   assign req.ready = ctrl_ready;

   pfld_dp #(
      .MAX_COLUMNS (MAX_COLUMNS),
      .MAX_PAGES   (MAX_PAGES)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .st            (st),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_wr_data   (csr_wr_data),
      .req_type      (req.req_type),
      .start_x       (req.start_x),
      .start_y       (req.start_y),
      .end_x         (req.end_x),
      .end_y         (req.end_y),
      .dashed        (req.dashed),
      .read_page     (req.read_page),
      .read_column   (req.read_column),
      .rsp_ready     (rsp.ready),
      .rsp_valid     (rsp.valid),
      .rsp_read_data (rsp.read_data),
      .rsp_was_read  (rsp.was_read),
      .mem_we        (mem_we),
      .mem_re        (mem_re),
      .mem_addr      (mem_addr),
      .mem_wdata     (mem_wdata),
      .mem_rdata     (mem_rdata)
   );

   pfld_ram #(
      .WIDTH (DATA_W),
      .DEPTH (DEPTH)
   ) u_frame_store (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_addr),
      .wr_data (mem_wdata),
      .rd_en   (mem_re),
      .rd_addr (mem_addr),
      .rd_data (mem_rdata)
   );

endmodule

// ===== src/pfld_checker.sv =====
// Port-level assertions for the page framebuffer line drawer, bound to the top level.
// Depends on pfld_pkg.
module pfld_checker import pfld_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [DATA_W-1:0] rsp_read_data,
   input logic              rsp_was_read
);

   logic [1:0] pend_ff;
   logic [1:0] pend_in;

   // commands accepted but not yet delivered
   always_comb begin
      pend_in = pend_ff;
      if (req_valid && req_ready) begin
         pend_in = pend_in + 2'd1;
      end
      if (rsp_valid && rsp_ready) begin
         pend_in = pend_in - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   a_clear_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !req_ready)
      else $error("req ready during store clearing pass");

   a_rsp_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_read_data) && $stable(rsp_was_read))
      else $error("stalled rsp beat changed");

   a_no_spurious_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pend_ff != 2'd0)
      else $error("rsp beat without an accepted command");

   a_pend_bound: assert property (@(posedge clock) disable iff (reset)
      pend_ff <= 2'd2)
      else $error("more than two commands outstanding");

   a_zero_non_read: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_was_read |-> rsp_read_data == '0)
      else $error("non-read result carries data");

endmodule

bind page_framebuffer_line_drawer pfld_checker u_pfld_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req.valid),
   .req_ready     (req.ready),
   .rsp_valid     (rsp.valid),
   .rsp_ready     (rsp.ready),
   .rsp_read_data (rsp.read_data),
   .rsp_was_read  (rsp.was_read)
);
